// ----- hw/rtl/rpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

  localparam int MAX_DISKS  = 8;
  localparam int UNIT_BITS  = 64;
  localparam int BLOCK_BITS = 12;

  localparam int DISK_BITS     = $clog2(MAX_DISKS);
  localparam int DISK_COUNT_W  = 4;
  localparam int UNIT_WIDTH_W  = 7;
  localparam int BLOCK_COUNT_W = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 2;

  // The failure scan walks the column words one byte-wide chunk per cycle.
  localparam int SCAN_STEP   = 8;
  localparam int SCAN_CHUNKS = UNIT_BITS / SCAN_STEP;
  localparam int CHUNK_IDX_W = $clog2(SCAN_CHUNKS);

  localparam logic [CFG_INDEX_W-1:0] REG_DISK_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ODD_PARITY  = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE   = 2'd2;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
  } scan_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rpr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rpr_fail_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpr_fail_scan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rpr_pkg::UNIT_BITS-1:0] fail_bits,
  input  wire logic [rpr_pkg::UNIT_BITS-1:0] twice_bits,
  output rpr_pkg::scan_result_t              result
);

  import rpr_pkg::*;

  logic                   busy;
  logic [CHUNK_IDX_W-1:0] chunk;
  logic [SCAN_STEP-1:0]   chunk_fail;
  logic [SCAN_STEP-1:0]   chunk_twice;
  logic [SCAN_STEP-1:0]   lowest;

  assign chunk_fail  = fail_bits[chunk*SCAN_STEP +: SCAN_STEP];
  assign chunk_twice = twice_bits[chunk*SCAN_STEP +: SCAN_STEP];
  // Isolate the lowest failing bit of the current chunk.
  assign lowest      = chunk_fail & (~chunk_fail + SCAN_STEP'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      chunk         <= '0;
      result.done   <= 1'b0;
      result.status <= STATUS_OK;
    end else begin
      result.done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        chunk <= '0;
      end else if (busy) begin
        if (|chunk_fail) begin
          busy          <= 1'b0;
          result.done   <= 1'b1;
          result.status <= (|(lowest & chunk_twice)) ? STATUS_DOUBLE : STATUS_MISMATCH;
        end else if (chunk == CHUNK_IDX_W'(SCAN_CHUNKS - 1)) begin
          busy          <= 1'b0;
          result.done   <= 1'b1;
          result.status <= STATUS_OK;
        end else begin
          chunk <= chunk + CHUNK_IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/raid_parity_repair_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A unit that does not close a row is taken in the idle state, and the block remains ready.
// A row-closing unit runs the failure scan (one byte of columns per cycle, then the registered
// result is handed over), then drains the row buffer with a RAM read and an output load per data
// unit plus an extra read step when the parity disk is not the top disk, the load waiting while
// the output is stalled; no new unit is taken meanwhile. Synchronous reset restores the register
// defaults and starts a new set at block 0; any configuration write also restarts the set.
module raid_parity_repair_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              unit_valid,
  output logic                                   unit_stall,
  input  wire logic [rpr_pkg::UNIT_BITS-1:0]     unit_data,
  input  wire logic [rpr_pkg::UNIT_BITS-1:0]     erased_mask,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic      [rpr_pkg::UNIT_BITS-1:0]     data_unit,
  output logic      [1:0]                        row_status,
  output logic                                   set_valid,
  output logic                                   row_last,
  output logic                                   set_last
);

  import rpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state;

  logic [DISK_COUNT_W-1:0]  disk_count;
  logic [UNIT_WIDTH_W-1:0]  unit_width;
  logic [BLOCK_COUNT_W-1:0] block_count;
  logic                     odd_parity;

  logic [DISK_BITS-1:0]  disk_position;
  logic [BLOCK_BITS-1:0] block_position;
  logic [DISK_BITS-1:0]  parity_disk;
  logic [DISK_BITS-1:0]  k;
  logic [UNIT_BITS-1:0]  xor_accumulator;
  logic [UNIT_BITS-1:0]  erased_once;
  logic [UNIT_BITS-1:0]  erased_twice;
  logic                  set_ok;
  logic [1:0]            status_q;

  logic [DISK_COUNT_W-1:0]  disks;
  logic [UNIT_WIDTH_W-1:0]  width_eff;
  logic [BLOCK_COUNT_W-1:0] blocks;
  logic [UNIT_BITS-1:0]     wmask;
  logic [UNIT_BITS-1:0]     pmask;
  logic [UNIT_BITS-1:0]     d_in;
  logic [UNIT_BITS-1:0]     e_in;
  logic [UNIT_BITS-1:0]     fail_bits;
  logic [UNIT_BITS-1:0]     restored;
  logic [UNIT_BITS-1:0]     buf_unit;
  logic [UNIT_BITS-1:0]     buf_erased;
  logic [UNIT_BITS-1:0]     repaired;
  logic [2*UNIT_BITS-1:0]   rdata;
  logic [DISK_BITS-1:0]     last_k;
  logic                     unit_accept;
  logic                     row_end;
  logic                     last_block;
  logic                     slot_free;
  logic                     cfg_hit;
  logic                     load_now;
  scan_result_t             scan;

  always_comb begin
    if (disk_count < DISK_COUNT_W'(2)) begin
      disks = DISK_COUNT_W'(2);
    end else if (disk_count > DISK_COUNT_W'(MAX_DISKS)) begin
      disks = DISK_COUNT_W'(MAX_DISKS);
    end else begin
      disks = disk_count;
    end
    if (unit_width == '0) begin
      width_eff = UNIT_WIDTH_W'(1);
    end else if (unit_width > UNIT_WIDTH_W'(UNIT_BITS)) begin
      width_eff = UNIT_WIDTH_W'(UNIT_BITS);
    end else begin
      width_eff = unit_width;
    end
    if (block_count == '0) begin
      blocks = BLOCK_COUNT_W'(1);
    end else if (block_count > BLOCK_COUNT_W'(1 << BLOCK_BITS)) begin
      blocks = BLOCK_COUNT_W'(1 << BLOCK_BITS);
    end else begin
      blocks = block_count;
    end
    for (int i = 0; i < UNIT_BITS; i++) begin
      wmask[i] = UNIT_WIDTH_W'(i) < width_eff;
    end
  end

  assign pmask       = odd_parity ? wmask : '0;
  assign d_in        = unit_data & wmask;
  assign e_in        = erased_mask & wmask;
  assign unit_stall  = (state != S_IDLE);
  assign unit_accept = unit_valid && !unit_stall;
  assign row_end     = ({1'b0, disk_position} + DISK_COUNT_W'(1)) >= disks;
  assign last_block  = ({1'b0, block_position} + BLOCK_COUNT_W'(1)) >= blocks;
  assign slot_free   = !result_valid || !result_stall;
  assign load_now    = (state == S_LOAD) && slot_free;

  // The last data disk is the top disk unless that one holds parity this row.
  assign last_k = (parity_disk == DISK_BITS'(disks - DISK_COUNT_W'(1)))
                ? DISK_BITS'(disks - DISK_COUNT_W'(2))
                : DISK_BITS'(disks - DISK_COUNT_W'(1));

  assign fail_bits  = (~erased_once & wmask & (xor_accumulator ^ pmask)) | erased_twice;
  assign restored   = (xor_accumulator ^ pmask) & wmask;
  assign buf_unit   = rdata[UNIT_BITS-1:0];
  assign buf_erased = rdata[2*UNIT_BITS-1:UNIT_BITS];
  assign repaired   = ((buf_unit & ~buf_erased)
                    | (buf_erased & erased_once & ~erased_twice & restored)) & wmask;

  assign cfg_hit = cfg_we && (cfg_index == REG_DISK_COUNT || cfg_index == REG_UNIT_WIDTH
                 || cfg_index == REG_BLOCK_COUNT || cfg_index == REG_ODD_PARITY);

  rpr_ram #(
    .WIDTH (2 * UNIT_BITS),
    .DEPTH (MAX_DISKS)
  ) u_row_buf (
    .clk   (clk),
    .we    (unit_accept),
    .waddr (disk_position),
    .wdata ({e_in, d_in}),
    .raddr (k),
    .rdata (rdata)
  );

  rpr_fail_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (unit_accept && row_end),
    .fail_bits  (fail_bits),
    .twice_bits (erased_twice),
    .result     (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      disk_count      <= DISK_COUNT_W'(3);
      unit_width      <= UNIT_WIDTH_W'(UNIT_BITS);
      block_count     <= BLOCK_COUNT_W'(1);
      odd_parity      <= 1'b0;
      disk_position   <= '0;
      block_position  <= '0;
      parity_disk     <= '0;
      k               <= '0;
      xor_accumulator <= '0;
      erased_once     <= '0;
      erased_twice    <= '0;
      set_ok          <= 1'b1;
      status_q        <= STATUS_OK;
      result_valid    <= 1'b0;
    end else begin
      // A loaded transaction stays valid until the receiver takes it.
      result_valid <= load_now || (result_valid && result_stall);
      case (state)
        S_IDLE: begin
          if (unit_accept) begin
            xor_accumulator <= xor_accumulator ^ (d_in & ~e_in);
            erased_twice    <= erased_twice | (erased_once & e_in);
            erased_once     <= erased_once | e_in;
            if (row_end) begin
              state <= S_SCAN;
            end else begin
              disk_position <= disk_position + DISK_BITS'(1);
            end
          end
        end
        S_SCAN: begin
          if (scan.done) begin
            status_q <= scan.status;
            if (scan.status != STATUS_OK) begin
              set_ok <= 1'b0;
            end
            k     <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (k == parity_disk) begin
            k <= k + DISK_BITS'(1);
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (slot_free) begin
            if (k == last_k) begin
              xor_accumulator <= '0;
              erased_once     <= '0;
              erased_twice    <= '0;
              disk_position   <= '0;
              state           <= S_IDLE;
              if (last_block) begin
                block_position <= '0;
                parity_disk    <= '0;
                set_ok         <= 1'b1;
              end else begin
                block_position <= block_position + BLOCK_BITS'(1);
                parity_disk    <= ({1'b0, parity_disk} + DISK_COUNT_W'(1) >= disks)
                                ? '0 : parity_disk + DISK_BITS'(1);
              end
            end else begin
              k     <= k + DISK_BITS'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_hit) begin
        case (cfg_index)
          REG_DISK_COUNT:  disk_count  <= cfg_data[DISK_COUNT_W-1:0];
          REG_UNIT_WIDTH:  unit_width  <= cfg_data[UNIT_WIDTH_W-1:0];
          REG_BLOCK_COUNT: block_count <= cfg_data[BLOCK_COUNT_W-1:0];
          REG_ODD_PARITY:  odd_parity  <= cfg_data[0];
          default: begin
          end
        endcase
        state           <= S_IDLE;
        disk_position   <= '0;
        block_position  <= '0;
        parity_disk     <= '0;
        xor_accumulator <= '0;
        erased_once     <= '0;
        erased_twice    <= '0;
        set_ok          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      data_unit  <= repaired;
      row_status <= status_q;
      set_valid  <= set_ok;
      row_last   <= (k == last_k);
      set_last   <= (k == last_k) && last_block;
    end
  end

  a_row_end_scans: assert property (@(posedge clk) disable iff (rst)
    (unit_accept && row_end && !cfg_hit) |=> (state == S_SCAN))
    else $error("row-closing transaction did not start the failure scan");

  a_scan_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan.done |-> (state == S_SCAN))
    else $error("failure scan finished outside the scan state");

  a_no_parity_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (k != parity_disk))
    else $error("parity disk selected for output");

  a_set_last_row_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && set_last) |-> row_last)
    else $error("set end flagged away from a row end");

endmodule

`default_nettype wire
